FILE: rtl/cdsd_pkg.sv
// Package for the card deck shuffle and deal block.
// Holds widths, mode and status codes, sequencer states and the card decode.
// No dependencies.
package cdsd_pkg;

    // Default deck size and card layout
    localparam int DECK_ENTRIES_DEF = 52;
    localparam int RANKS_PER_SUIT   = 13;
    localparam int SUIT_COUNT       = 4;
    localparam int CODE_W           = 6;

    // Request and result field widths
    localparam int MODE_W   = 2;
    localparam int WORD_W   = 32;
    localparam int STATUS_W = 2;
    localparam int RANK_W   = 4;
    localparam int SUIT_W   = 2;

    typedef enum logic [MODE_W-1:0] {
        MODE_INIT      = 2'd0,
        MODE_SHUFFLE   = 2'd1,
        MODE_DEAL_UP   = 2'd2,
        MODE_DEAL_DOWN = 2'd3
    } mode_t;

    typedef enum logic [STATUS_W-1:0] {
        STS_DEALT     = 2'd0,
        STS_EXHAUSTED = 2'd1,
        STS_STEP      = 2'd2,
        STS_COMPLETE  = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_RD_POS,
        ST_WR_POS,
        ST_WR_J,
        ST_DEAL_WAIT,
        ST_EMIT
    } state_t;

    // Status of the remainder unit towards the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } mod_sts_t;

    // Card code to rank 1..13: code mod 13 by repeated subtraction (code < 64)
    function automatic logic [RANK_W-1:0] card_rank_f(input logic [CODE_W-1:0] code);
        logic [CODE_W-1:0] r;
        r = code;
        for (int i = 0; i < 4; i++) begin
            if (r >= CODE_W'(RANKS_PER_SUIT)) begin
                r = r - CODE_W'(RANKS_PER_SUIT);
            end
        end
        return RANK_W'(r) + RANK_W'(1);
    endfunction

    // Card code to suit: (code / 13) mod 4, the low quotient bits
    function automatic logic [SUIT_W-1:0] card_suit_f(input logic [CODE_W-1:0] code);
        logic [CODE_W-1:0] r;
        logic [2:0]        q;
        r = code;
        q = '0;
        for (int i = 0; i < 4; i++) begin
            if (r >= CODE_W'(RANKS_PER_SUIT)) begin
                r = r - CODE_W'(RANKS_PER_SUIT);
                q = q + 3'd1;
            end
        end
        return q[SUIT_W-1:0];
    endfunction

endpackage

FILE: rtl/cdsd_if.sv
// Handshake interfaces for the request and result channels.
// Depends on cdsd_pkg for field widths.
interface cdsd_cmd_if
    import cdsd_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [MODE_W-1:0]   mode;
    logic [WORD_W-1:0]   random_word;

    modport source (output valid, output mode, output random_word, input ready);
    modport sink   (input valid, input mode, input random_word, output ready);
endinterface

interface cdsd_rsp_if
    import cdsd_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [RANK_W-1:0]   card_rank;
    logic [SUIT_W-1:0]   card_suit;
    logic                face_up;

    modport source (output valid, output status, output card_rank, output card_suit,
                    output face_up, input ready);
    modport sink   (input valid, input status, input card_rank, input card_suit,
                    input face_up, output ready);
endinterface

FILE: rtl/cdsd_ram.sv
// Generic single write port, single read port RAM with registered read.
// No dependencies.
module cdsd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/cdsd_mod.sv
// Bit-serial remainder unit: 32-bit word modulo a small divisor, one bit a cycle.
// Depends on cdsd_pkg for WORD_W and mod_sts_t.
module cdsd_mod
    import cdsd_pkg::*;
#(
    parameter int DIV_W = 6,
    parameter int REM_W = 6
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [WORD_W-1:0] dividend,
    input  logic [DIV_W-1:0]  divisor,
    output mod_sts_t          sts,
    output logic [REM_W-1:0]  remainder
);

    localparam int CNT_W = $clog2(WORD_W);

    logic              busy_reg,  busy_next;
    logic              done_reg,  done_next;
    logic [CNT_W-1:0]  cnt_reg,   cnt_next;
    logic [WORD_W-1:0] word_reg,  word_next;
    logic [DIV_W-1:0]  div_reg,   div_next;
    logic [DIV_W-1:0]  rem_reg,   rem_next;
    logic [DIV_W:0]    trial;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            word_reg <= '0;
            div_reg  <= '0;
            rem_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
            word_reg <= word_next;
            div_reg  <= div_next;
            rem_reg  <= rem_next;
        end
    end

    // One restoring step: shift in the next dividend bit, subtract if it fits
    assign trial = {rem_reg, word_reg[WORD_W-1]};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        word_next = word_reg;
        div_next  = div_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(WORD_W - 1);
            word_next = dividend;
            div_next  = divisor;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            word_next = {word_reg[WORD_W-2:0], 1'b0};
            if (trial >= {1'b0, div_reg})
            begin
                rem_next = DIV_W'(trial - {1'b0, div_reg});
            end
            else
            begin
                rem_next = DIV_W'(trial);
            end
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    assign sts.busy  = busy_reg;
    assign sts.done  = done_reg;
    // Remainder is below the divisor, so it fits an entry index
    assign remainder = REM_W'(rem_reg);

endmodule

FILE: rtl/card_deck_shuffle_and_deal_top.sv
// Top level of the card deck shuffle and deal block: sequencer, pointers, valid bits.
// Depends on cdsd_pkg, cdsd_if, cdsd_ram and cdsd_mod.
//
//   channel | modport | fields                                   | role
//   --------+---------+------------------------------------------+-----------------------
//   cmd     | sink    | mode, random_word                        | init, shuffle, deal
//   rsp     | source  | status, card_rank, card_suit, face_up    | one result per request
//
// From one acceptance to the next: init goes straight to the result load, a deal reads
// its entry and then loads the result, and a deal on an exhausted deck goes straight to
// the result load. A shuffle step runs the bit-serial remainder unit (a restoring step
// per dividend bit and a done cycle, the last also reading the shuffle-position entry),
// then the partner read, the two writes of the swap and the result load. One request
// is worked on at a time. Reset (and init) clears the per-entry valid bits; an entry
// not yet written reads as its ordered code, so no clearing pass is needed.
// A result waits in the output register; a stalled result channel holds the sequencer
// only when the next result is ready to be loaded.
module card_deck_shuffle_and_deal_top
    import cdsd_pkg::*;
#(
    parameter int DECK_ENTRIES = DECK_ENTRIES_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    cdsd_cmd_if.sink   cmd,
    cdsd_rsp_if.source rsp
);

    localparam int POS_W = $clog2(DECK_ENTRIES);
    localparam int CNT_W = $clog2(DECK_ENTRIES + 1);
    localparam logic [POS_W-1:0] LAST_POS = POS_W'(DECK_ENTRIES - 1);
    localparam logic [CNT_W-1:0] DEAL_END = CNT_W'(DECK_ENTRIES);

    state_t             state_reg,     state_next;
    mode_t              mode_reg,      mode_next;
    logic [CNT_W-1:0]   deal_reg,      deal_next;
    logic [POS_W-1:0]   spos_reg,      spos_next;
    logic [POS_W-1:0]   pos_reg,       pos_next;
    logic [POS_W-1:0]   j_reg,         j_next;
    logic [CODE_W-1:0]  dp_reg,        dp_next;
    logic [DECK_ENTRIES-1:0] valid_reg, valid_next;
    logic [POS_W-1:0]   rd_addr_reg;
    logic               rd_vld_reg;
    status_t            res_status_reg, res_status_next;
    logic [RANK_W-1:0]  res_rank_reg,  res_rank_next;
    logic [SUIT_W-1:0]  res_suit_reg,  res_suit_next;
    logic               res_up_reg,    res_up_next;
    logic               out_valid_reg, out_valid_next;
    status_t            out_status_reg, out_status_next;
    logic [RANK_W-1:0]  out_rank_reg,  out_rank_next;
    logic [SUIT_W-1:0]  out_suit_reg,  out_suit_next;
    logic               out_up_reg,    out_up_next;

    logic               ram_we;
    logic [POS_W-1:0]   ram_waddr;
    logic [CODE_W-1:0]  ram_wdata;
    logic [POS_W-1:0]   ram_raddr;
    logic [CODE_W-1:0]  ram_q;
    logic [CODE_W-1:0]  code_rd;
    logic [POS_W-1:0]   pos_eff;
    logic [CNT_W-1:0]   divisor;
    logic               mod_start;
    mod_sts_t           mod_sts;
    logic [POS_W-1:0]   mod_rem;

    // Deck memory
    cdsd_ram #(
        .WIDTH (CODE_W),
        .DEPTH (DECK_ENTRIES)
    ) u_deck (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_q)
    );

    // Remainder unit for the swap partner
    cdsd_mod #(
        .DIV_W (CNT_W),
        .REM_W (POS_W)
    ) u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (mod_start),
        .dividend  (cmd.random_word),
        .divisor   (divisor),
        .sts       (mod_sts),
        .remainder (mod_rem)
    );

    // Shuffle position in range, and the modulus it gives
    assign pos_eff = (spos_reg == '0 || CNT_W'(spos_reg) >= DEAL_END) ? LAST_POS : spos_reg;
    assign divisor = CNT_W'(pos_eff) + CNT_W'(1);

    // Read address per state
    always_comb
    begin
        unique case (state_reg)
            ST_IDLE:   ram_raddr = deal_reg[POS_W-1:0];
            ST_RD_POS: ram_raddr = j_reg;
            default:   ram_raddr = pos_reg;
        endcase
    end

    // An entry never written since reset or init reads as its ordered code
    assign code_rd = rd_vld_reg ? ram_q : CODE_W'(rd_addr_reg);

    // Registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            mode_reg       <= MODE_INIT;
            deal_reg       <= '0;
            spos_reg       <= LAST_POS;
            pos_reg        <= LAST_POS;
            j_reg          <= '0;
            dp_reg         <= '0;
            valid_reg      <= '0;
            rd_addr_reg    <= '0;
            rd_vld_reg     <= 1'b0;
            res_status_reg <= STS_DEALT;
            res_rank_reg   <= '0;
            res_suit_reg   <= '0;
            res_up_reg     <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_status_reg <= STS_DEALT;
            out_rank_reg   <= '0;
            out_suit_reg   <= '0;
            out_up_reg     <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            mode_reg       <= mode_next;
            deal_reg       <= deal_next;
            spos_reg       <= spos_next;
            pos_reg        <= pos_next;
            j_reg          <= j_next;
            dp_reg         <= dp_next;
            valid_reg      <= valid_next;
            rd_addr_reg    <= ram_raddr;
            rd_vld_reg     <= (CNT_W'(ram_raddr) < DEAL_END) ? valid_reg[ram_raddr] : 1'b0;
            res_status_reg <= res_status_next;
            res_rank_reg   <= res_rank_next;
            res_suit_reg   <= res_suit_next;
            res_up_reg     <= res_up_next;
            out_valid_reg  <= out_valid_next;
            out_status_reg <= out_status_next;
            out_rank_reg   <= out_rank_next;
            out_suit_reg   <= out_suit_next;
            out_up_reg     <= out_up_next;
        end
    end

    // Sequencer: next state, memory accesses, pointers and result
    always_comb
    begin
        state_next      = state_reg;
        mode_next       = mode_reg;
        deal_next       = deal_reg;
        spos_next       = spos_reg;
        pos_next        = pos_reg;
        j_next          = j_reg;
        dp_next         = dp_reg;
        valid_next      = valid_reg;
        res_status_next = res_status_reg;
        res_rank_next   = res_rank_reg;
        res_suit_next   = res_suit_reg;
        res_up_next     = res_up_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_status_next = out_status_reg;
        out_rank_next   = out_rank_reg;
        out_suit_next   = out_suit_reg;
        out_up_next     = out_up_reg;
        ram_we          = 1'b0;
        ram_waddr       = pos_reg;
        ram_wdata       = code_rd;
        mod_start       = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd.valid)
                begin
                    mode_next     = mode_t'(cmd.mode);
                    res_rank_next = '0;
                    res_suit_next = '0;
                    res_up_next   = 1'b0;
                    unique case (mode_t'(cmd.mode))
                        MODE_INIT:
                        begin
                            valid_next      = '0;
                            deal_next       = '0;
                            spos_next       = LAST_POS;
                            res_status_next = STS_COMPLETE;
                            state_next      = ST_EMIT;
                        end
                        MODE_SHUFFLE:
                        begin
                            pos_next   = pos_eff;
                            mod_start  = 1'b1;
                            state_next = ST_DIV;
                        end
                        MODE_DEAL_UP, MODE_DEAL_DOWN:
                        begin
                            if (deal_reg == DEAL_END)
                            begin
                                res_status_next = STS_EXHAUSTED;
                                state_next      = ST_EMIT;
                            end
                            else
                            begin
                                state_next = ST_DEAL_WAIT;
                            end
                        end
                    endcase
                end
            end
            ST_DIV:
            begin
                if (mod_sts.done)
                begin
                    j_next     = mod_rem;
                    state_next = ST_RD_POS;
                end
            end
            ST_RD_POS:
            begin
                // Entry at the shuffle position arrives; partner read goes out
                dp_next    = code_rd;
                state_next = ST_WR_POS;
            end
            ST_WR_POS:
            begin
                ram_we     = 1'b1;
                ram_waddr  = pos_reg;
                ram_wdata  = code_rd;
                state_next = ST_WR_J;
            end
            ST_WR_J:
            begin
                ram_we    = 1'b1;
                ram_waddr = j_reg;
                ram_wdata = dp_reg;
                if (pos_reg == POS_W'(1))
                begin
                    deal_next       = '0;
                    spos_next       = LAST_POS;
                    res_status_next = STS_COMPLETE;
                end
                else
                begin
                    spos_next       = pos_reg - POS_W'(1);
                    res_status_next = STS_STEP;
                end
                state_next = ST_EMIT;
            end
            ST_DEAL_WAIT:
            begin
                res_status_next = STS_DEALT;
                res_rank_next   = card_rank_f(code_rd);
                res_suit_next   = card_suit_f(code_rd);
                res_up_next     = (mode_reg == MODE_DEAL_UP);
                deal_next       = deal_reg + CNT_W'(1);
                state_next      = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_rank_next   = res_rank_reg;
                    out_suit_next   = res_suit_reg;
                    out_up_next     = res_up_reg;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // A written entry holds memory data from now on
        if (ram_we)
        begin
            valid_next[ram_waddr] = 1'b1;
        end
    end

    // Ports
    assign cmd.ready     = (state_reg == ST_IDLE);
    assign rsp.valid     = out_valid_reg;
    assign rsp.status    = out_status_reg;
    assign rsp.card_rank = out_rank_reg;
    assign rsp.card_suit = out_suit_reg;
    assign rsp.face_up   = out_up_reg;

`ifndef ASSERT_OFF
    // Deal pointer never passes the exhausted value
    a_deal_range: assert property (@(posedge clk) disable iff (!rst_n)
        deal_reg <= DEAL_END)
        else $error("deal pointer out of range");

    // Shuffle position stays a nonzero entry index
    a_spos_range: assert property (@(posedge clk) disable iff (!rst_n)
        spos_reg != '0 && CNT_W'(spos_reg) < DEAL_END)
        else $error("shuffle position out of range");

    // Remainder unit runs only while the sequencer waits on it
    a_mod_owned: assert property (@(posedge clk) disable iff (!rst_n)
        mod_sts.busy |-> state_reg == ST_DIV)
        else $error("remainder unit busy outside divide state");

    // A dealt card carries a rank of ace to king
    a_rank_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.status == STS_DEALT) |->
            (rsp.card_rank != '0 && rsp.card_rank <= RANK_W'(RANKS_PER_SUIT)))
        else $error("dealt card with bad rank");
`endif

endmodule
